// ===== rtl/htc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package htc_pkg;

   localparam int MAX_POLY_VERTS_DEF = 16;
   localparam int COORD_BITS_DEF     = 32;
   localparam int TFRAC              = 30;
   localparam int MAX_TRIS           = 5;
   localparam int TQ_DEPTH           = 2;
   localparam int RSP_DEPTH          = 4;
   localparam int DIST_W             = 34;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } vertex_type;

   typedef struct packed {
      vertex_type [2:0] v;
      logic [7:0]       tag;
   } tri_type;

   typedef struct packed {
      vertex_type v;
      logic [7:0] tag;
      logic       eot;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      PLANE_BOTTOM = 2'd0,
      PLANE_RIGHT  = 2'd1,
      PLANE_LEFT   = 2'd2,
      PLANE_TOP    = 2'd3
   } plane_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PASS_START,
      ST_PASS_FIRST,
      ST_EDGE_RD,
      ST_EDGE_EVAL,
      ST_DIV_WAIT,
      ST_MUL,
      ST_ADD,
      ST_WR_CROSS,
      ST_PUSH_B,
      ST_PASS_END,
      ST_EMIT_CHK,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   function automatic logic signed [DIST_W-1:0] plane_dist(plane_type p, vertex_type v);
      logic signed [DIST_W-1:0] x;
      logic signed [DIST_W-1:0] y;
      logic signed [DIST_W-1:0] w;
      logic signed [DIST_W-1:0] d;
      x = DIST_W'($signed(v.x));
      y = DIST_W'($signed(v.y));
      w = DIST_W'($signed(v.w));
      case (p)
         PLANE_BOTTOM: d = -y - w;
         PLANE_RIGHT:  d = x - w;
         PLANE_LEFT:   d = -x - w;
         PLANE_TOP:    d = y - w;
         default:      d = '0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/htc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module htc_front import htc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_pos_w,
   input  wire logic [7:0]  req_tri_tag,
   output logic             tri_valid,
   output tri_type          tri_head,
   input  wire logic        tri_pop
);
   localparam int PW = $clog2(TQ_DEPTH);

   logic [1:0]  phase_ff, phase_in;
   vertex_type  v0_ff, v0_in, v1_ff, v1_in;
   logic [7:0]  tag_ff, tag_in;
   tri_type     q_ff [TQ_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   vertex_type  cur;
   logic        acc, enq;

   function automatic logic [31:0] sext(logic [31:0] v);
      logic signed [COORD_BITS-1:0] t;
      t = v[COORD_BITS-1:0];
      return 32'(t);
   endfunction

   assign cur  = '{x: sext(req_pos_x), y: sext(req_pos_y), z: sext(req_pos_z),
                   w: sext(req_pos_w)};
   assign full = (cnt_ff == (PW+1)'(TQ_DEPTH));
   assign acc  = push && !full;
   assign enq  = acc && (phase_ff == 2'd2);
   assign tri_valid = (cnt_ff != '0);
   assign tri_head  = q_ff[rp_ff];

   always_comb begin
      phase_in = phase_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      tag_in = tag_ff;
      if (acc) begin
         case (phase_ff)
            2'd1: begin
               v1_in = cur;
               phase_in = 2'd2;
            end
            2'd2: phase_in = 2'd0;
            default: begin
               v0_in = cur;
               tag_in = req_tri_tag;
               phase_in = 2'd1;
            end
         endcase
      end
      wp_in  = enq ? wp_ff + 1'b1 : wp_ff;
      rp_in  = (tri_pop && tri_valid) ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(enq) - (PW+1)'(tri_pop && tri_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         tag_ff <= '0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tag_ff <= tag_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      if (enq) begin
         q_ff[wp_ff] <= '{v: '{cur, v1_ff, v0_ff}, tag: tag_ff};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/htc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module htc_div import htc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIST_W-1:0] num,
   input  wire logic [DIST_W:0]   den,
   output logic                   done,
   output logic [TFRAC-1:0]       quot
);
   localparam int CW = $clog2(TFRAC + 1);

   logic [DIST_W:0]   rem_ff, rem_in;
   logic [DIST_W:0]   den_ff, den_in;
   logic [TFRAC-1:0]  q_ff, q_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIST_W+1:0] r2;

   assign r2   = {rem_ff, 1'b0};
   assign done = busy_ff && (cnt_ff == '0);
   assign quot = q_ff;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = {1'b0, num};
         den_in = den;
         q_in = '0;
         cnt_in = CW'(TFRAC);
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != '0) begin
         if (r2 >= {1'b0, den_ff}) begin
            rem_in = (DIST_W+1)'(r2 - {1'b0, den_ff});
            q_in = {q_ff[TFRAC-2:0], 1'b1};
         end else begin
            rem_in = r2[DIST_W:0];
            q_in = {q_ff[TFRAC-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end
endmodule
`default_nettype wire

// ===== rtl/htc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module htc_back import htc_pkg::*; #(
   parameter int MAX_POLY_VERTS = MAX_POLY_VERTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    tri_valid,
   input  tri_type      tri_head,
   output logic         tri_pop,
   output logic         rsp_push,
   output rsp_type      rsp_data,
   input  wire logic    rsp_full
);
   localparam int IW = $clog2(MAX_POLY_VERTS);
   localparam int CW = $clog2(MAX_POLY_VERTS + 1);

   state_type state_ff, state_in;
   vertex_type mem [2*MAX_POLY_VERTS];
   vertex_type rdata_ff;
   logic [IW:0] rd_addr, wr_addr;
   logic        wr_en;
   vertex_type  wr_data;

   logic [1:0]    ld_ff, ld_in;
   logic [7:0]    tag_ff, tag_in;
   logic          bank_ff, bank_in;
   plane_type     pass_ff, pass_in;
   logic [CW-1:0] len_ff, len_in, nl_ff, nl_in, j_ff, j_in;
   vertex_type    a_ff, a_in, b_ff, b_in, p_ff, p_in, q_ff, q_in, x_ff, x_in;
   logic signed [DIST_W-1:0] db_ff, db_in, da, db;
   logic [1:0]    co_ff, co_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [2:0]    ntri_ff, ntri_in, tri_ff, tri_in;
   logic [1:0]    pos_ff, pos_in;
   logic          div_start, div_done;
   logic [DIST_W-1:0] div_num;
   logic [DIST_W:0]   div_den;
   logic [TFRAC-1:0]  t;
   logic [CW-1:0] jn;
   logic          cross_ab, cross_ba, last_v;
   logic signed [32:0] diff;
   logic signed [63:0] rnd;
   logic [31:0]   pc, qc, newc;

   htc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(t)
   );

   assign da = plane_dist(pass_ff, a_ff);
   assign db = plane_dist(pass_ff, rdata_ff);
   assign cross_ab = (da > 0) && (db < 0);
   assign cross_ba = (db > 0) && (da < 0);
   assign jn = j_ff + 1'b1;
   assign last_v = (pos_ff == 2'd2) && (tri_ff == ntri_ff - 1'b1);

   always_comb begin
      case (co_ff)
         2'd0: begin pc = p_ff.x; qc = q_ff.x; end
         2'd1: begin pc = p_ff.y; qc = q_ff.y; end
         2'd2: begin pc = p_ff.z; qc = q_ff.z; end
         default: begin pc = p_ff.w; qc = q_ff.w; end
      endcase
      diff = 33'($signed(qc)) - 33'($signed(pc));
      rnd  = prod_ff + 64'sd536870912;
      newc = 32'($signed(pc) + 32'(rnd >>> TFRAC));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (tri_valid) state_in = ST_LOAD;
         ST_LOAD:       if (ld_ff == 2'd2) state_in = ST_PASS_START;
         ST_PASS_START: state_in = (len_ff == '0) ? ST_PASS_END : ST_PASS_FIRST;
         ST_PASS_FIRST: state_in = ST_EDGE_RD;
         ST_EDGE_RD:    state_in = ST_EDGE_EVAL;
         ST_EDGE_EVAL:  state_in = (cross_ab || cross_ba) ? ST_DIV_WAIT : ST_PUSH_B;
         ST_DIV_WAIT:   if (div_done) state_in = ST_MUL;
         ST_MUL:        state_in = ST_ADD;
         ST_ADD:        state_in = (co_ff == 2'd3) ? ST_WR_CROSS : ST_MUL;
         ST_WR_CROSS:   state_in = ST_PUSH_B;
         ST_PUSH_B:     state_in = (jn == len_ff) ? ST_PASS_END : ST_EDGE_RD;
         ST_PASS_END:   state_in = (pass_ff == PLANE_TOP) ? ST_EMIT_CHK : ST_PASS_START;
         ST_EMIT_CHK:   state_in = (len_ff < CW'(3)) ? ST_IDLE : ST_EMIT_RD;
         ST_EMIT_RD:    state_in = ST_EMIT_WR;
         ST_EMIT_WR:    if (!rsp_full) state_in = last_v ? ST_IDLE : ST_EMIT_RD;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ld_in = ld_ff; tag_in = tag_ff; bank_in = bank_ff; pass_in = pass_ff;
      len_in = len_ff; nl_in = nl_ff; j_in = j_ff;
      a_in = a_ff; b_in = b_ff; p_in = p_ff; q_in = q_ff; x_in = x_ff;
      db_in = db_ff; co_in = co_ff; prod_in = prod_ff;
      ntri_in = ntri_ff; tri_in = tri_ff; pos_in = pos_ff;
      tri_pop = 1'b0; rsp_push = 1'b0;
      wr_en = 1'b0; wr_addr = {~bank_ff, nl_ff[IW-1:0]}; wr_data = b_ff;
      div_start = 1'b0; div_num = '0; div_den = '0;
      rd_addr = {bank_ff, {IW{1'b0}}};
      rsp_data = '{v: rdata_ff, tag: tag_ff, eot: pos_ff == 2'd2, last: last_v};
      case (state_ff)
         ST_IDLE: begin
            ld_in = '0;
         end
         ST_LOAD: begin
            wr_en = 1'b1;
            wr_addr = {1'b0, IW'(ld_ff)};
            wr_data = tri_head.v[ld_ff];
            tag_in = tri_head.tag;
            ld_in = ld_ff + 1'b1;
            if (ld_ff == 2'd2) begin
               tri_pop = 1'b1;
               bank_in = 1'b0;
               pass_in = PLANE_BOTTOM;
               len_in = CW'(3);
            end
         end
         ST_PASS_START: begin
            nl_in = '0;
            j_in = '0;
         end
         ST_PASS_FIRST: a_in = rdata_ff;
         ST_EDGE_RD: rd_addr = {bank_ff, (jn == len_ff) ? {IW{1'b0}} : jn[IW-1:0]};
         ST_EDGE_EVAL: begin
            b_in = rdata_ff;
            db_in = db;
            co_in = '0;
            if (cross_ab) begin
               p_in = a_ff; q_in = rdata_ff;
               div_start = 1'b1;
               div_num = DIST_W'(da);
               div_den = (DIST_W+1)'(da) - (DIST_W+1)'(db);
            end else if (cross_ba) begin
               p_in = rdata_ff; q_in = a_ff;
               div_start = 1'b1;
               div_num = DIST_W'(db);
               div_den = (DIST_W+1)'(db) - (DIST_W+1)'(da);
            end
         end
         ST_MUL: prod_in = diff * $signed({1'b0, t});
         ST_ADD: begin
            case (co_ff)
               2'd0: x_in.x = newc;
               2'd1: x_in.y = newc;
               2'd2: x_in.z = newc;
               default: x_in.w = newc;
            endcase
            co_in = co_ff + 1'b1;
         end
         ST_WR_CROSS: begin
            if (nl_ff < CW'(MAX_POLY_VERTS)) begin
               wr_en = 1'b1;
               wr_data = x_ff;
               nl_in = nl_ff + 1'b1;
            end
         end
         ST_PUSH_B: begin
            if (db_ff < 0 && nl_ff < CW'(MAX_POLY_VERTS)) begin
               wr_en = 1'b1;
               nl_in = nl_ff + 1'b1;
            end
            a_in = b_ff;
            j_in = jn;
         end
         ST_PASS_END: begin
            len_in = nl_ff;
            bank_in = ~bank_ff;
            pass_in = plane_type'(pass_ff + 2'd1);
         end
         ST_EMIT_CHK: begin
            ntri_in = (len_ff >= CW'(MAX_TRIS + 2)) ? 3'(MAX_TRIS) : 3'(len_ff - CW'(2));
            tri_in = '0;
            pos_in = '0;
         end
         ST_EMIT_RD, ST_EMIT_WR: begin
            rd_addr = {bank_ff, (pos_ff == '0) ? {IW{1'b0}} : IW'(tri_ff + 3'(pos_ff))};
            if (state_ff == ST_EMIT_WR && !rsp_full) begin
               rsp_push = 1'b1;
               if (pos_ff == 2'd2) begin
                  pos_in = '0;
                  tri_in = tri_ff + 1'b1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ld_ff <= ld_in; tag_ff <= tag_in; bank_ff <= bank_in; pass_ff <= pass_in;
      len_ff <= len_in; nl_ff <= nl_in; j_ff <= j_in;
      a_ff <= a_in; b_ff <= b_in; p_ff <= p_in; q_ff <= q_in; x_ff <= x_in;
      db_ff <= db_in; co_ff <= co_in; prod_ff <= prod_in;
      ntri_ff <= ntri_in; tri_ff <= tri_in; pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/htc_rsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module htc_rsp_fifo import htc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr,
   input  rsp_type   wdata,
   output logic      fifo_full,
   output logic      fifo_empty,
   input  wire logic rd,
   output rsp_type   rdata
);
   localparam int PW = $clog2(RSP_DEPTH);

   rsp_type       q_ff [RSP_DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0]   cnt_ff;
   logic          do_wr, do_rd;

   assign fifo_full  = (cnt_ff == (PW+1)'(RSP_DEPTH));
   assign fifo_empty = (cnt_ff == '0);
   assign do_wr = wr && !fifo_full;
   assign do_rd = rd && !fifo_empty;
   assign rdata = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + PW'(do_wr);
         rp_ff <= rp_ff + PW'(do_rd);
         cnt_ff <= cnt_ff + (PW+1)'(do_wr) - (PW+1)'(do_rd);
      end
      if (do_wr) begin
         q_ff[wp_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/homogeneous_triangle_clipper.sv =====
// Output: nothing results from the first two vertex transactions; after the third, the
//   triangle is queued and its results follow once the clip engine has run on it.
// Flow: one triangle at a time in the clip engine; the front queue holds further triangles,
//   and run time is set by the per-edge sequencer and the bit-serial divider per crossing.
// Reset: synchronous, active high; clears vertex phase, queues and engine state.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_triangle_clipper import htc_pkg::*; #(
   parameter int MAX_POLY_VERTS = MAX_POLY_VERTS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_pos_w,
   input  wire logic [7:0]  req_tri_tag,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_clip_x,
   output logic [31:0]      rsp_clip_y,
   output logic [31:0]      rsp_clip_z,
   output logic [31:0]      rsp_clip_w,
   output logic [7:0]       rsp_out_tag,
   output logic             rsp_end_of_triangle,
   output logic             rsp_last_of_run
);
   logic    tri_valid, tri_pop, rsp_push, rsp_full;
   tri_type tri_head;
   rsp_type rsp_w, rsp_r;

   htc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_pos_w(req_pos_w), .req_tri_tag(req_tri_tag),
      .tri_valid(tri_valid), .tri_head(tri_head), .tri_pop(tri_pop)
   );

   htc_back #(.MAX_POLY_VERTS(MAX_POLY_VERTS)) u_back (
      .clock(clock), .reset(reset), .tri_valid(tri_valid), .tri_head(tri_head),
      .tri_pop(tri_pop), .rsp_push(rsp_push), .rsp_data(rsp_w), .rsp_full(rsp_full)
   );

   htc_rsp_fifo u_rsp (
      .clock(clock), .reset(reset), .wr(rsp_push), .wdata(rsp_w),
      .fifo_full(rsp_full), .fifo_empty(empty), .rd(pop), .rdata(rsp_r)
   );

   assign rsp_clip_x = rsp_r.v.x;
   assign rsp_clip_y = rsp_r.v.y;
   assign rsp_clip_z = rsp_r.v.z;
   assign rsp_clip_w = rsp_r.v.w;
   assign rsp_out_tag = rsp_r.tag;
   assign rsp_end_of_triangle = rsp_r.eot;
   assign rsp_last_of_run = rsp_r.last;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");
   a_last_is_eot: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_run) |-> rsp_end_of_triangle)
      else $error("last vertex of run not at end of triangle");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full || !rsp_push)
      else $error("result push while full");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import htc_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int HOLD_CYCLES    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push  = 1'b0;
   logic        pop   = 1'b0;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0, req_pos_w = '0;
   logic [7:0]  req_tri_tag = '0;
   logic        full, empty;
   logic [31:0] rsp_clip_x, rsp_clip_y, rsp_clip_z, rsp_clip_w;
   logic [7:0]  rsp_out_tag;
   logic        rsp_end_of_triangle, rsp_last_of_run;

   rsp_type    expected_vertices[$];
   vertex_type tri_verts[3];
   int         vert_count = 0;
   logic [7:0] tri_tag_held = '0;
   int         errors = 0;
   int         quiet_cycles = 0;
   bit         rx_hold = 1'b0;
   bit         no_idle = 1'b0;

   homogeneous_triangle_clipper dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_pos_w(req_pos_w), .req_tri_tag(req_tri_tag),
      .empty(empty), .pop(pop),
      .rsp_clip_x(rsp_clip_x), .rsp_clip_y(rsp_clip_y), .rsp_clip_z(rsp_clip_z),
      .rsp_clip_w(rsp_clip_w), .rsp_out_tag(rsp_out_tag),
      .rsp_end_of_triangle(rsp_end_of_triangle), .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint side_dist(plane_type p, vertex_type v);
      longint x, y, w;
      x = longint'($signed(v.x));
      y = longint'($signed(v.y));
      w = longint'($signed(v.w));
      case (p)
         PLANE_BOTTOM: return -y - w;
         PLANE_RIGHT:  return x - w;
         PLANE_LEFT:   return -x - w;
         default:      return y - w;
      endcase
   endfunction

   function automatic vertex_type crossing(vertex_type p, vertex_type q, longint dp, longint dq);
      longint unsigned t;
      longint diff, prod;
      logic [31:0] pc[4], qc[4], rc[4];
      vertex_type r;
      t = (longint'(dp) << 30) / longint'(dp - dq);
      pc = '{p.x, p.y, p.z, p.w};
      qc = '{q.x, q.y, q.z, q.w};
      for (int c = 0; c < 4; c++) begin
         diff = longint'($signed(qc[c])) - longint'($signed(pc[c]));
         prod = diff * longint'(t) + (longint'(1) << 29);
         rc[c] = 32'(longint'($signed(pc[c])) + (prod >>> 30));
      end
      r.x = rc[0]; r.y = rc[1]; r.z = rc[2]; r.w = rc[3];
      return r;
   endfunction

   task automatic predict_triangle();
      vertex_type src[$], dst[$];
      vertex_type a, b;
      longint da, db;
      int ntri;
      rsp_type r;
      src = '{tri_verts[0], tri_verts[1], tri_verts[2]};
      for (int k = 0; k < 4; k++) begin
         dst.delete();
         for (int j = 0; j < src.size(); j++) begin
            a = src[j];
            b = src[(j + 1) % src.size()];
            da = side_dist(plane_type'(k), a);
            db = side_dist(plane_type'(k), b);
            if (da > 0 && db < 0) begin
               if (dst.size() < MAX_POLY_VERTS_DEF) dst.push_back(crossing(a, b, da, db));
            end else if (db > 0 && da < 0) begin
               if (dst.size() < MAX_POLY_VERTS_DEF) dst.push_back(crossing(b, a, db, da));
            end
            if (db < 0 && dst.size() < MAX_POLY_VERTS_DEF) dst.push_back(b);
         end
         src = dst;
      end
      if (src.size() < 3) return;
      ntri = src.size() - 2;
      if (ntri > MAX_TRIS) ntri = MAX_TRIS;
      r.tag = tri_tag_held;
      for (int j = 0; j < ntri; j++) begin
         r.eot = 1'b0; r.last = 1'b0;
         r.v = src[0];     expected_vertices.push_back(r);
         r.v = src[j + 1]; expected_vertices.push_back(r);
         r.v = src[j + 2]; r.eot = 1'b1; r.last = (j == ntri - 1);
         expected_vertices.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (push && !full) begin
            tri_verts[vert_count] = '{req_pos_x, req_pos_y, req_pos_z, req_pos_w};
            if (vert_count == 0) tri_tag_held = req_tri_tag;
            if (vert_count == 2) begin
               vert_count = 0;
               predict_triangle();
            end else begin
               vert_count++;
            end
         end
         if (pop && !empty) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch("unexpected result transaction", '0, '0);
            end else begin
               e = expected_vertices.pop_front();
               if (rsp_clip_x !== e.v.x) report_mismatch("clip_x", rsp_clip_x, e.v.x);
               if (rsp_clip_y !== e.v.y) report_mismatch("clip_y", rsp_clip_y, e.v.y);
               if (rsp_clip_z !== e.v.z) report_mismatch("clip_z", rsp_clip_z, e.v.z);
               if (rsp_clip_w !== e.v.w) report_mismatch("clip_w", rsp_clip_w, e.v.w);
               if (rsp_out_tag !== e.tag) report_mismatch("out_tag", rsp_out_tag, e.tag);
               if (rsp_end_of_triangle !== e.eot)
                  report_mismatch("end_of_triangle", rsp_end_of_triangle, e.eot);
               if (rsp_last_of_run !== e.last)
                  report_mismatch("last_of_run", rsp_last_of_run, e.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      if (no_idle) return 0;
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 3);
   endfunction

   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold = 1'b0;
         end
         n = gap_len();
         if (n > 0) begin
            pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_vertex(logic [31:0] x, y, z, w, logic [7:0] tag);
      int n;
      push <= 1'b1;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z; req_pos_w <= w;
      req_tri_tag <= tag;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      n = gap_len();
      if (n > 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] q16(int v);
      return 32'(v * 65536);
   endfunction

   task automatic send_random_vertex(int kind);
      int w;
      logic [31:0] z;
      z = $urandom;
      if (kind == 0) begin
         send_vertex($urandom, $urandom, z, $urandom, 8'($urandom));
      end else begin
         w = $urandom_range(1, 1 << 22);
         send_vertex(32'($signed($urandom_range(0, 4 * w)) - 2 * w),
                     32'($signed($urandom_range(0, 4 * w)) - 2 * w),
                     z, 32'(w), 8'($urandom));
      end
   endtask

   task automatic test_inside();
      send_vertex(q16(0), q16(0), q16(1), q16(1), 8'h5a);
      send_vertex(q16(0) + 32'h4000, q16(0), q16(2), q16(1), 8'h11);
      send_vertex(q16(0), q16(0) + 32'h4000, q16(3), q16(1), 8'h22);
   endtask

   task automatic test_big_fan();
      send_vertex(q16(-3), q16(0), q16(0), q16(1), 8'hff);
      send_vertex(q16(3), q16(-3), q16(0), q16(1), 8'h00);
      send_vertex(q16(3), q16(3), q16(0), q16(1), 8'h00);
      send_vertex(q16(0), q16(-5), 32'h7fffffff, q16(2), 8'h00);
      send_vertex(q16(5), q16(5), 32'h80000000, q16(2), 8'hff);
      send_vertex(q16(-5), q16(4), 32'h00000001, q16(2), 8'hff);
   endtask

   task automatic test_on_plane();
      send_vertex(q16(1), q16(0), q16(0), q16(1), 8'h33);
      send_vertex(q16(0), q16(1), q16(0), q16(1), 8'h44);
      send_vertex(q16(0), q16(0), q16(0), q16(1), 8'h55);
      send_vertex(q16(2), q16(0), q16(0), q16(1), 8'h66);
      send_vertex(q16(1), q16(0), q16(0), q16(1), 8'h77);
      send_vertex(q16(0), q16(-1), q16(0), q16(1), 8'h88);
   endtask

   task automatic test_extremes();
      send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 8'h01);
      send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 8'h02);
      send_vertex(32'h00000000, 32'h00000000, 32'hffffffff, 32'h7fffffff, 8'h03);
      send_vertex(32'h80000000, 32'h80000000, 32'h0, 32'h80000000, 8'h04);
      send_vertex(32'h7fffffff, 32'h7fffffff, 32'h0, 32'h80000000, 8'h05);
      send_vertex(32'hffffffff, 32'h00000001, 32'h0, 32'h00000000, 8'h06);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 30) no_idle = ~no_idle;
         send_random_vertex($urandom_range(0, 4) == 0 ? 0 : 1);
      end
      no_idle = 1'b0;
   endtask

   // triangles fully inside, so every one produces results while the receiver holds off
   task automatic test_backpressure();
      rx_hold = 1'b1;
      for (int i = 0; i < 10; i++) begin
         send_vertex(q16(0), q16(0), 32'($urandom), q16(1), 8'($urandom));
         send_vertex(32'h4000, q16(0), 32'($urandom), q16(1), 8'($urandom));
         send_vertex(q16(0), 32'h4000, 32'($urandom), q16(1), 8'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_inside();
      test_big_fan();
      test_on_plane();
      test_extremes();
      test_backpressure();
      test_random(330);
      push <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
